// ===== hdl/sfpr_pkg.sv =====
// Shared types, codes and helpers for the sync-framed packet receiver.
package sfpr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [2:0] HEADER_BYTES   = 3'd6;
  localparam logic [3:0] FRAME_OVERHEAD = 4'd8;

  localparam logic [1:0] STATUS_GOOD    = 2'd0;
  localparam logic [1:0] STATUS_CK_ERR  = 2'd1;
  localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

  typedef enum logic [1:0] {
    SKIP_NONE,
    SKIP_ADD1,
    SKIP_ADD2
  } skip_op_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_LEN_ERR,
    EMIT_CK_ERR,
    EMIT_EMPTY,
    EMIT_DATA
  } emit_op_t;

  typedef struct packed {
    logic     sum_clear;
    logic     sum_run;
    logic     cap_class;
    logic     cap_id;
    logic     cap_len_lo;
    logic     cap_len_hi;
    logic     seen_clear;
    logic     store_byte;
    logic     cap_ck_a;
    logic     rd_clear;
    logic     rd_issue;
    skip_op_t skip_op;
    emit_op_t emit_op;
  } sfpr_cmd_t;

  typedef struct packed {
    logic is_sync1;
    logic is_sync2;
    logic len_over;
    logic more_payload;
    logic ck_ok;
    logic len_zero;
    logic drain_last;
    logic out_free;
  } sfpr_sts_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [10:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {6'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// ===== hdl/sfpr_if.sv =====
// Valid-ready channel interfaces for received bytes and frame results.
interface sfpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfpr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  class_code;
  logic [7:0]  msg_id;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic [5:0]  byte_offset;
  logic        last;
  logic [15:0] skipped_bytes;

  modport source (
    output valid, output status, output class_code, output msg_id,
    output payload_length, output data_byte, output data_valid,
    output byte_offset, output last, output skipped_bytes, input ready
  );
  modport sink (
    input valid, input status, input class_code, input msg_id,
    input payload_length, input data_byte, input data_valid,
    input byte_offset, input last, input skipped_bytes, output ready
  );
endinterface

// ===== hdl/sfpr_ctrl.sv =====
// Frame parsing and payload drain state machine of the packet receiver.
module sfpr_ctrl import sfpr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sfpr_sts_t sts,
  output sfpr_cmd_t cmd
);

  localparam logic [3:0] S_HUNT     = 4'd0;
  localparam logic [3:0] S_SYNC     = 4'd1;
  localparam logic [3:0] S_CLASS    = 4'd2;
  localparam logic [3:0] S_ID       = 4'd3;
  localparam logic [3:0] S_LEN_LO   = 4'd4;
  localparam logic [3:0] S_LEN_HI   = 4'd5;
  localparam logic [3:0] S_PAYLOAD  = 4'd6;
  localparam logic [3:0] S_CK_B     = 4'd7;
  localparam logic [3:0] S_DRAIN_RD = 4'd8;
  localparam logic [3:0] S_DRAIN_LD = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       parsing;
  logic       accept;

  assign parsing  = (state inside {S_HUNT, S_SYNC, S_CLASS, S_ID, S_LEN_LO, S_LEN_HI,
                                   S_PAYLOAD, S_CK_B});
  assign in_ready = parsing && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.skip_op = SKIP_NONE;
    cmd.emit_op = EMIT_NONE;
    state_next = state;
    case (state)
      S_HUNT: begin
        if (accept) begin
          if (sts.is_sync1) state_next = S_SYNC;
          else cmd.skip_op = SKIP_ADD1;
        end
      end
      S_SYNC: begin
        if (accept) begin
          if (sts.is_sync2) begin
            cmd.sum_clear = 1'b1;
            state_next    = S_CLASS;
          end else if (sts.is_sync1) begin
            cmd.skip_op = SKIP_ADD1;
          end else begin
            cmd.skip_op = SKIP_ADD2;
            state_next  = S_HUNT;
          end
        end
      end
      S_CLASS: begin
        if (accept) begin
          cmd.cap_class = 1'b1;
          cmd.sum_run   = 1'b1;
          state_next    = S_ID;
        end
      end
      S_ID: begin
        if (accept) begin
          cmd.cap_id  = 1'b1;
          cmd.sum_run = 1'b1;
          state_next  = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        if (accept) begin
          cmd.cap_len_lo = 1'b1;
          cmd.sum_run    = 1'b1;
          state_next     = S_LEN_HI;
        end
      end
      S_LEN_HI: begin
        if (accept) begin
          cmd.cap_len_hi = 1'b1;
          cmd.sum_run    = 1'b1;
          cmd.seen_clear = 1'b1;
          if (sts.len_over) begin
            cmd.emit_op = EMIT_LEN_ERR;
            state_next  = S_HUNT;
          end else begin
            state_next = S_PAYLOAD;
          end
        end
      end
      S_PAYLOAD: begin
        if (accept) begin
          if (sts.more_payload) begin
            cmd.store_byte = 1'b1;
            cmd.sum_run    = 1'b1;
          end else begin
            cmd.cap_ck_a = 1'b1;
            state_next   = S_CK_B;
          end
        end
      end
      S_CK_B: begin
        if (accept) begin
          if (!sts.ck_ok) begin
            cmd.emit_op = EMIT_CK_ERR;
            state_next  = S_HUNT;
          end else if (sts.len_zero) begin
            cmd.emit_op = EMIT_EMPTY;
            state_next  = S_HUNT;
          end else begin
            cmd.rd_clear = 1'b1;
            state_next   = S_DRAIN_RD;
          end
        end
      end
      S_DRAIN_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_DRAIN_LD;
      end
      S_DRAIN_LD: begin
        if (sts.out_free) begin
          cmd.emit_op = EMIT_DATA;
          state_next  = sts.drain_last ? S_HUNT : S_DRAIN_RD;
        end
      end
      default: state_next = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_HUNT;
    else state <= state_next;
  end

endmodule

// ===== hdl/sfpr_datapath.sv =====
// Header registers, Fletcher sums, payload buffer, skip counter and result register.
module sfpr_datapath import sfpr_pkg::*; #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  sfpr_cmd_t   cmd,
  output sfpr_sts_t   sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  class_code,
  output logic [7:0]  msg_id,
  output logic [15:0] payload_length,
  output logic [7:0]  data_byte,
  output logic        data_valid,
  output logic [5:0]  byte_offset,
  output logic        last,
  output logic [15:0] skipped_bytes
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]    frame_class;
  logic [7:0]    frame_id;
  logic [15:0]   frame_length;
  logic [15:0]   len_full;
  logic [CW-1:0] bytes_seen;
  logic [CW-1:0] rd_idx;
  logic [7:0]    sum_a;
  logic [7:0]    sum_b;
  logic [7:0]    sum_a_next;
  logic [7:0]    received_ck_a;
  logic [15:0]   skip_count;
  logic [7:0]    rd_data;
  logic [7:0]    payload_store [MAX_PAYLOAD];
  logic          emit;
  logic          emit_last;

  assign len_full   = {rx_byte, frame_length[7:0]};
  assign sum_a_next = sum_a + rx_byte;
  assign emit       = (cmd.emit_op != EMIT_NONE);
  assign emit_last  = (cmd.emit_op == EMIT_DATA) ? sts.drain_last : emit;

  assign sts.is_sync1     = (rx_byte == SYNC_FIRST);
  assign sts.is_sync2     = (rx_byte == SYNC_SECOND);
  assign sts.len_over     = (len_full > 16'(MAX_PAYLOAD));
  assign sts.more_payload = (16'(bytes_seen) < frame_length);
  assign sts.ck_ok        = (received_ck_a == sum_a) && (rx_byte == sum_b);
  assign sts.len_zero     = (frame_length == 16'd0);
  assign sts.drain_last   = ((16'(rd_idx) + 16'd1) == frame_length);
  assign sts.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.sum_clear) begin
      sum_a <= 8'd0;
      sum_b <= 8'd0;
    end else if (cmd.sum_run) begin
      sum_a <= sum_a_next;
      sum_b <= sum_b + sum_a_next;
    end
    if (cmd.cap_class) frame_class <= rx_byte;
    if (cmd.cap_id) frame_id <= rx_byte;
    if (cmd.cap_len_lo) frame_length <= {8'd0, rx_byte};
    if (cmd.cap_len_hi) frame_length <= len_full;
    if (cmd.cap_ck_a) received_ck_a <= rx_byte;
    if (cmd.seen_clear) bytes_seen <= '0;
    else if (cmd.store_byte) bytes_seen <= bytes_seen + CW'(1);
    if (cmd.store_byte) payload_store[bytes_seen[AW-1:0]] <= rx_byte;
    if (cmd.rd_issue) rd_data <= payload_store[rd_idx[AW-1:0]];
    if (cmd.rd_clear) rd_idx <= '0;
    else if (cmd.emit_op == EMIT_DATA) rd_idx <= rd_idx + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skip_count <= 16'd0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (emit_last) skip_count <= 16'd0;
      else if (cmd.skip_op == SKIP_ADD1) skip_count <= sat_add16(skip_count, 11'd1);
      else if (cmd.skip_op == SKIP_ADD2) skip_count <= sat_add16(skip_count, 11'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      class_code     <= frame_class;
      msg_id         <= frame_id;
      payload_length <= frame_length;
      data_byte      <= 8'd0;
      data_valid     <= 1'b0;
      byte_offset    <= 6'd0;
      last           <= emit_last;
      skipped_bytes  <= skip_count;
      status         <= STATUS_GOOD;
      case (cmd.emit_op)
        EMIT_LEN_ERR: begin
          status         <= STATUS_LEN_ERR;
          payload_length <= len_full;
          skipped_bytes  <= sat_add16(skip_count, 11'(HEADER_BYTES));
        end
        EMIT_CK_ERR: begin
          status        <= STATUS_CK_ERR;
          skipped_bytes <= sat_add16(skip_count,
                                     11'(frame_length) + 11'(FRAME_OVERHEAD));
        end
        EMIT_DATA: begin
          data_byte   <= rd_data;
          data_valid  <= 1'b1;
          byte_offset <= 6'(rd_idx);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/sync_framed_packet_receiver_top.sv =====
// Top level of the sync-framed packet receiver with Fletcher checksum check.
// Each received byte is one transaction and is taken while the block parses the
// frame; a byte is held off only while a previous result still waits in the
// output register. A frame with a good checksum then releases its payload from
// the internal buffer as one result transaction per byte, each read from
// the buffer into a register first, and no byte is taken during that drain.
// Error frames and empty frames give one result transaction, loaded in the
// same cycle as the byte that completes them.
module sync_framed_packet_receiver_top import sfpr_pkg::*; #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic      clk,
  input  logic      rst,
  sfpr_rx_if.sink   rx,
  sfpr_res_if.source res
);

  sfpr_cmd_t cmd;
  sfpr_sts_t sts;

  sfpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfpr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx.rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .status         (res.status),
    .class_code     (res.class_code),
    .msg_id         (res.msg_id),
    .payload_length (res.payload_length),
    .data_byte      (res.data_byte),
    .data_valid     (res.data_valid),
    .byte_offset    (res.byte_offset),
    .last           (res.last),
    .skipped_bytes  (res.skipped_bytes)
  );

endmodule

// ===== tb/sfpr_checker.sv =====
// Frame result predictor and scoreboard that watches the byte and result channels.
module sfpr_checker import sfpr_pkg::*; #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic clk,
  input  logic rst,
  sfpr_rx_if   rx,
  sfpr_res_if  res,
  output int   fail_count,
  output int   pending,
  output int   good_frames,
  output int   bad_frames
);

  typedef enum logic [2:0] {
    HUNT,
    SYNC_SEEN,
    TAKE_CLASS,
    TAKE_ID,
    TAKE_LEN_LO,
    TAKE_LEN_HI,
    TAKE_PAYLOAD,
    TAKE_CK_B
  } deframe_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  class_code;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic [5:0]  byte_offset;
    logic        last;
    logic [15:0] skipped_bytes;
  } frame_result_t;

  deframe_state_t state;
  logic [7:0]  frame_class;
  logic [7:0]  frame_id;
  logic [15:0] frame_length;
  logic [15:0] payload_seen;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [7:0]  got_ck_a;
  logic [15:0] skip_count;
  logic [7:0]  payload_copy [MAX_PAYLOAD];
  frame_result_t results_due [$];
  int errs = 0;
  int n_good = 0;
  int n_bad = 0;

  function automatic logic [15:0] skip_plus(input logic [15:0] a, input int unsigned n);
    int unsigned s;
    s = 32'(a) + n;
    return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void fletcher_add(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic void push_due(input logic [1:0] st, input logic [7:0] data,
                                   input logic dv, input logic [5:0] offs,
                                   input logic lst, input logic [15:0] sk);
    results_due.push_back('{st, frame_class, frame_id, frame_length, data, dv, offs,
                            lst, sk});
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    int i;
    case (state)
      HUNT: begin
        if (b == SYNC_FIRST) state = SYNC_SEEN;
        else skip_count = skip_plus(skip_count, 1);
      end
      SYNC_SEEN: begin
        if (b == SYNC_SECOND) begin
          state = TAKE_CLASS;
          sum_a = 8'h00;
          sum_b = 8'h00;
        end else if (b == SYNC_FIRST) begin
          skip_count = skip_plus(skip_count, 1);
        end else begin
          skip_count = skip_plus(skip_count, 2);
          state = HUNT;
        end
      end
      TAKE_CLASS: begin
        frame_class = b;
        fletcher_add(b);
        state = TAKE_ID;
      end
      TAKE_ID: begin
        frame_id = b;
        fletcher_add(b);
        state = TAKE_LEN_LO;
      end
      TAKE_LEN_LO: begin
        frame_length = {8'h00, b};
        fletcher_add(b);
        state = TAKE_LEN_HI;
      end
      TAKE_LEN_HI: begin
        frame_length = {b, frame_length[7:0]};
        fletcher_add(b);
        payload_seen = 16'd0;
        if (frame_length > MAX_PAYLOAD) begin
          push_due(STATUS_LEN_ERR, 8'h00, 1'b0, 6'd0, 1'b1, skip_plus(skip_count, 6));
          n_bad++;
          skip_count = 16'd0;
          state = HUNT;
        end else begin
          state = TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        if (payload_seen < frame_length) begin
          if (payload_seen < MAX_PAYLOAD) payload_copy[payload_seen] = b;
          fletcher_add(b);
          payload_seen = payload_seen + 16'd1;
        end else begin
          got_ck_a = b;
          state = TAKE_CK_B;
        end
      end
      default: begin
        if (got_ck_a == sum_a && b == sum_b) begin
          if (frame_length == 16'd0) begin
            push_due(STATUS_GOOD, 8'h00, 1'b0, 6'd0, 1'b1, skip_count);
          end else begin
            for (i = 0; i < frame_length && i < MAX_PAYLOAD; i++) begin
              push_due(STATUS_GOOD, payload_copy[i], 1'b1, i[5:0],
                       (16'(i + 1) == frame_length), skip_count);
            end
          end
          n_good++;
        end else begin
          push_due(STATUS_CK_ERR, 8'h00, 1'b0, 6'd0, 1'b1,
                   skip_plus(skip_count, 32'(frame_length) + 32'(FRAME_OVERHEAD)));
          n_bad++;
        end
        skip_count = 16'd0;
        state = HUNT;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endfunction

  function automatic void check_result();
    frame_result_t want;
    if (results_due.size() == 0) begin
      $error("result transaction with no frame result due: status %0d, last %0b",
             res.status, res.last);
      errs++;
    end else begin
      want = results_due.pop_front();
      check_field("status", 16'(want.status), 16'(res.status));
      check_field("class_code", 16'(want.class_code), 16'(res.class_code));
      check_field("msg_id", 16'(want.msg_id), 16'(res.msg_id));
      check_field("payload_length", want.payload_length, res.payload_length);
      check_field("data_byte", 16'(want.data_byte), 16'(res.data_byte));
      check_field("data_valid", 16'(want.data_valid), 16'(res.data_valid));
      check_field("byte_offset", 16'(want.byte_offset), 16'(res.byte_offset));
      check_field("last", 16'(want.last), 16'(res.last));
      check_field("skipped_bytes", want.skipped_bytes, res.skipped_bytes);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      state = HUNT;
      frame_class = 8'h00;
      frame_id = 8'h00;
      frame_length = 16'd0;
      payload_seen = 16'd0;
      sum_a = 8'h00;
      sum_b = 8'h00;
      got_ck_a = 8'h00;
      skip_count = 16'd0;
      results_due.delete();
    end else begin
      if (rx.valid && rx.ready) deframe_byte(rx.rx_byte);
      if (res.valid && res.ready) check_result();
    end
    fail_count <= errs;
    pending <= results_due.size();
    good_frames <= n_good;
    bad_frames <= n_bad;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, byte stream stimulus, watchdog and verdict.
module tb_top;
  import sfpr_pkg::*;

  localparam int MAX_PAYLOAD = 64;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_BYTES = 22;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic ready_q = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  int fail_count;
  int pending;
  int good_frames;
  int bad_frames;

  sfpr_rx_if rx_ch();
  sfpr_res_if res_ch();

  sync_framed_packet_receiver_top #(.MAX_PAYLOAD(MAX_PAYLOAD)) uut (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .res(res_ch)
  );

  sfpr_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) frame_chk (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .res(res_ch),
    .fail_count(fail_count),
    .pending(pending),
    .good_frames(good_frames),
    .bad_frames(bad_frames)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  assign res_ch.ready = ready_q;

  always @(posedge clk) begin
    ready_q <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_noise(input int n);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom_range(255));
      if (b == SYNC_FIRST) b = ~b;
      send_byte(b);
    end
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input logic corrupt);
    logic [7:0] ca;
    logic [7:0] cb;
    logic [7:0] pb;
    logic [7:0] mask;
    logic [7:0] hdr [4];
    ca = 8'h00;
    cb = 8'h00;
    hdr = '{cls, id, len[7:0], len[15:8]};
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    foreach (hdr[k]) begin
      ca = ca + hdr[k];
      cb = cb + ca;
      send_byte(hdr[k]);
    end
    if (len > MAX_PAYLOAD) return;
    for (int k = 0; k < len; k++) begin
      pb = 8'($urandom_range(255));
      ca = ca + pb;
      cb = cb + ca;
      send_byte(pb);
    end
    if (corrupt) begin
      mask = 8'($urandom_range(1, 255));
      case ($urandom_range(2))
        0: ca = ca ^ mask;
        1: cb = cb ^ mask;
        default: begin
          ca = ca ^ mask;
          cb = cb ^ mask;
        end
      endcase
    end
    send_byte(ca);
    send_byte(cb);
  endtask

  task automatic send_random_frame();
    int pick;
    logic [15:0] len;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 15) begin
      if ($urandom_range(1) == 1) begin
        b = 8'($urandom_range(255));
        if (b == SYNC_FIRST || b == SYNC_SECOND) b = 8'h00;
        send_byte(SYNC_FIRST);
        send_byte(b);
      end else begin
        send_noise($urandom_range(1, 3));
      end
    end else begin
      if ($urandom_range(3) == 0) send_byte(SYNC_FIRST);
      pick = $urandom_range(99);
      if (pick < 5) len = 16'd64;
      else if (pick < 8) len = 16'd65;
      else if (pick < 12) len = 16'($urandom_range(66, 65535));
      else if (pick < 20) len = 16'($urandom_range(9, 63));
      else len = 16'($urandom_range(0, 8));
      send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
                 $urandom_range(99) < 12);
    end
  endtask

  initial begin
    int base;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_byte(SYNC_FIRST);
    send_byte(8'h13);
    send_byte(SYNC_FIRST);
    send_frame(8'hFF, 8'h00, 16'd0, 1'b0);
    send_frame(8'h01, 8'h02, 16'hFFFF, 1'b0);
    send_frame(8'h80, 8'h7F, 16'd1, 1'b1);

    send_frame(8'h5A, 8'hA5, 16'd64, 1'b0);
    send_noise(3);
    send_frame(8'h0A, 8'h01, 16'd4, 1'b1);
    send_frame(8'h0A, 8'h02, 16'd0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 57;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 57;
        end
        default: begin
          idle_pct = 16;
          stall_pct = 16;
        end
      endcase
      base = bytes_sent;
      while (bytes_sent - base < PHASE_BYTES) send_random_frame();
    end
    rx_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);

    $display("Run sent %0d bytes: directed edge frames, then four idling phases.",
             bytes_sent);
    $display("Checked results of %0d good frames and %0d rejected frames.",
             good_frames, bad_frames);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
